@@ src/convl_pkg.sv @@
// ----------------------------------------------------------------------------
// convl_pkg
// Shared types, sizes, divider constants and the sequencer program for the
// 5x5 multichannel convolution layer with ReLU.
// ----------------------------------------------------------------------------
package convl_pkg;

  // layer geometry
  localparam int DATA_W       = 16;
  localparam int IN_CHANNELS  = 6;
  localparam int OUT_CHANNELS = 16;
  localparam int IN_SIZE      = 14;
  localparam int KERNEL_SIZE  = 5;

  localparam int OUT_SIZE  = IN_SIZE - KERNEL_SIZE + 1;
  localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PIX_PLANE = IN_SIZE * IN_SIZE;
  localparam int OUT_PLANE = OUT_SIZE * OUT_SIZE;
  localparam int W_PER_OC  = IN_CHANNELS * TAPS;
  localparam int W_DEPTH   = OUT_CHANNELS * W_PER_OC;
  localparam int P_DEPTH   = IN_CHANNELS * PIX_PLANE;
  localparam int O_DEPTH   = OUT_CHANNELS * OUT_PLANE;

  // transaction field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 12;
  localparam int OUT_W = 15;

  // fixed point
  localparam int FRAC_BITS = 8;
  localparam longint SAT_RAW = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint SAT_MAX = (SAT_RAW < 32767) ? SAT_RAW : 32767;

  // storage widths
  localparam int PA_W = (PIX_PLANE > 1) ? $clog2(PIX_PLANE) : 1;
  localparam int WA_W = (OUT_CHANNELS * TAPS > 1) ? $clog2(OUT_CHANNELS * TAPS) : 1;
  localparam int OC_W = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int TAP_W = $clog2(TAPS + 1);
  localparam int KC_W  = $clog2(KERNEL_SIZE + 1);

  // accumulation widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + $clog2(IN_CHANNELS + 1) + 1;
  localparam int ACC_W  = PROD_W + $clog2(W_PER_OC + 1) + 1;
  localparam int TOT_W  = ACC_W + 1;

  // reciprocal division: q = (x * ceil(2^S / d)) >> S, exact for 12-bit x
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_W       = RECIP_W + IDX_W;
  localparam longint RECIP_PLANE = ((longint'(1) << RECIP_SHIFT) + OUT_PLANE - 1) / OUT_PLANE;
  localparam longint RECIP_OSIZE = ((longint'(1) << RECIP_SHIFT) + OUT_SIZE - 1) / OUT_SIZE;
  localparam longint RECIP_WOC   = ((longint'(1) << RECIP_SHIFT) + W_PER_OC - 1) / W_PER_OC;
  localparam longint RECIP_TAPS  = ((longint'(1) << RECIP_SHIFT) + TAPS - 1) / TAPS;
  localparam longint RECIP_PIX   = ((longint'(1) << RECIP_SHIFT) + PIX_PLANE - 1) / PIX_PLANE;

  typedef enum logic [OP_W-1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_BIAS   = 2'd1,
    OP_WR_PIXEL  = 2'd2,
    OP_RD_OUTPUT = 2'd3
  } op_e;

  // micro operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_QUOT,
    UOP_REM,
    UOP_SETUP,
    UOP_ISSUE,
    UOP_WR_WEIGHT,
    UOP_WR_BIAS,
    UOP_WR_PIXEL,
    UOP_RESULT,
    UOP_BAD
  } uop_e;

  typedef enum logic [2:0] {
    DIV_PLANE,
    DIV_OSIZE,
    DIV_WOC,
    DIV_TAPS,
    DIV_PIX
  } div_e;

  typedef enum logic {
    SRC_IDX,
    SRC_REM
  } src_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_LOOP,
    SEQ_IF_BAD,
    SEQ_DONE
  } seq_e;

  localparam int STEP_W = 5;

  typedef struct packed {
    uop_e              uop;
    div_e              div;
    src_e              src;
    seq_e              seq;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // program entry points and jump targets
  localparam logic [STEP_W-1:0] ENT_WEIGHT = 5'd0;
  localparam logic [STEP_W-1:0] ENT_BIAS   = 5'd5;
  localparam logic [STEP_W-1:0] ENT_PIXEL  = 5'd6;
  localparam logic [STEP_W-1:0] ENT_READ   = 5'd9;
  localparam logic [STEP_W-1:0] ST_MAC     = 5'd14;
  localparam logic [STEP_W-1:0] ST_BAD     = 5'd19;

  localparam ctrl_word_t CW_IDLE = '{UOP_NOP, DIV_PLANE, SRC_IDX, SEQ_NEXT, '0};

  function automatic logic [STEP_W-1:0] entry_of(input op_e op);
    logic [STEP_W-1:0] ent;
    case (op)
      OP_WR_WEIGHT: ent = ENT_WEIGHT;
      OP_WR_BIAS:   ent = ENT_BIAS;
      OP_WR_PIXEL:  ent = ENT_PIXEL;
      default:      ent = ENT_READ;
    endcase
    return ent;
  endfunction

  // control store
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    case (step)
      // weight write: oc, then ic and tap
      5'd0:  cw = '{UOP_QUOT,      DIV_WOC,   SRC_IDX, SEQ_NEXT,   '0};
      5'd1:  cw = '{UOP_REM,       DIV_WOC,   SRC_IDX, SEQ_NEXT,   '0};
      5'd2:  cw = '{UOP_QUOT,      DIV_TAPS,  SRC_REM, SEQ_NEXT,   '0};
      5'd3:  cw = '{UOP_REM,       DIV_TAPS,  SRC_REM, SEQ_NEXT,   '0};
      5'd4:  cw = '{UOP_WR_WEIGHT, DIV_TAPS,  SRC_REM, SEQ_DONE,   '0};
      // bias write
      5'd5:  cw = '{UOP_WR_BIAS,   DIV_PLANE, SRC_IDX, SEQ_DONE,   '0};
      // pixel write: channel, then offset in plane
      5'd6:  cw = '{UOP_QUOT,      DIV_PIX,   SRC_IDX, SEQ_NEXT,   '0};
      5'd7:  cw = '{UOP_REM,       DIV_PIX,   SRC_IDX, SEQ_NEXT,   '0};
      5'd8:  cw = '{UOP_WR_PIXEL,  DIV_PIX,   SRC_IDX, SEQ_DONE,   '0};
      // output read: oc, row, col, then the tap loop and pipeline drain
      5'd9:  cw = '{UOP_QUOT,      DIV_PLANE, SRC_IDX, SEQ_IF_BAD, ST_BAD};
      5'd10: cw = '{UOP_REM,       DIV_PLANE, SRC_IDX, SEQ_NEXT,   '0};
      5'd11: cw = '{UOP_QUOT,      DIV_OSIZE, SRC_REM, SEQ_NEXT,   '0};
      5'd12: cw = '{UOP_REM,       DIV_OSIZE, SRC_REM, SEQ_NEXT,   '0};
      5'd13: cw = '{UOP_SETUP,     DIV_PLANE, SRC_IDX, SEQ_NEXT,   '0};
      5'd14: cw = '{UOP_ISSUE,     DIV_PLANE, SRC_IDX, SEQ_LOOP,   ST_MAC};
      5'd15: cw = '{UOP_NOP,       DIV_PLANE, SRC_IDX, SEQ_NEXT,   '0};
      5'd16: cw = '{UOP_NOP,       DIV_PLANE, SRC_IDX, SEQ_NEXT,   '0};
      5'd17: cw = '{UOP_NOP,       DIV_PLANE, SRC_IDX, SEQ_NEXT,   '0};
      5'd18: cw = '{UOP_RESULT,    DIV_PLANE, SRC_IDX, SEQ_DONE,   '0};
      5'd19: cw = '{UOP_BAD,       DIV_PLANE, SRC_IDX, SEQ_DONE,   '0};
      default: cw = '{UOP_NOP,     DIV_PLANE, SRC_IDX, SEQ_DONE,   '0};
    endcase
    return cw;
  endfunction

  function automatic logic [RECIP_W-1:0] div_recip(input div_e d);
    logic [RECIP_W-1:0] m;
    case (d)
      DIV_PLANE: m = RECIP_W'(RECIP_PLANE);
      DIV_OSIZE: m = RECIP_W'(RECIP_OSIZE);
      DIV_WOC:   m = RECIP_W'(RECIP_WOC);
      DIV_TAPS:  m = RECIP_W'(RECIP_TAPS);
      default:   m = RECIP_W'(RECIP_PIX);
    endcase
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] div_den(input div_e d);
    logic [IDX_W-1:0] n;
    case (d)
      DIV_PLANE: n = IDX_W'(OUT_PLANE);
      DIV_OSIZE: n = IDX_W'(OUT_SIZE);
      DIV_WOC:   n = IDX_W'(W_PER_OC);
      DIV_TAPS:  n = IDX_W'(TAPS);
      default:   n = IDX_W'(PIX_PLANE);
    endcase
    return n;
  endfunction

endpackage

@@ src/conv_layer_6to16_5x5_relu_top.sv @@
// ----------------------------------------------------------------------------
// conv_layer_6to16_5x5_relu_top
// Valid 5x5 convolution, six 14x14 input maps to sixteen 10x10 output maps,
// with per-channel bias and ReLU, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Each transaction either writes one weight, one bias or one input pixel, or
// asks for one output pixel. A transaction is taken when start is high and
// busy is low. Writes give no result; a write whose index lies outside its
// store is dropped. A read gives exactly one result, shown for a single cycle
// with result_valid_o high; the receiver cannot stall it and must take it
// then. The result strobe comes in the cycle busy falls. A normal read runs
// the 25-step tap loop: six channel multipliers work in parallel, one kernel
// tap per cycle, each fed by its own weight and pixel memory port, followed
// by a 4-stage read/multiply/add pipeline. Reading a store entry that was
// never written gives an undefined result. Values are signed Q8.8; products
// are summed exactly, the bias added, negatives clamped to zero, then floored
// to Q8.8 and saturated to 32767.
// ----------------------------------------------------------------------------
module conv_layer_6to16_5x5_relu_top
  import convl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [IDX_W-1:0]         index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     result_valid_o,
  output logic [OUT_W-1:0]         out_value_o,
  output logic [IDX_W-1:0]         out_index_o,
  output logic                     bad_index_o
);

  // sequencer state
  logic              run_q, run_d;
  logic [STEP_W-1:0] step_q, step_d;
  ctrl_word_t        cw;

  // captured transaction
  logic [IDX_W-1:0]         idx_q;
  logic signed [DATA_W-1:0] val_q;

  // index decomposition registers
  logic [IDX_W-1:0] quo_q, q1_q, rem_q;
  logic [IDX_W-1:0] div_src;
  logic [DIV_W-1:0] div_prod;
  logic [2*IDX_W-1:0] den_prod;

  // tap loop counters and addresses
  logic [PA_W-1:0]  pa_q;
  logic [WA_W-1:0]  wa_q;
  logic [KC_W-1:0]  kc_q;
  logic [TAP_W-1:0] tap_q;
  logic [2*IDX_W-1:0] pa_base, wa_base;

  // mac pipeline
  logic                     rd_v_q, prod_v_q, sum_v_q;
  logic signed [DATA_W-1:0] p_rd_q [IN_CHANNELS];
  logic signed [DATA_W-1:0] w_rd_q [IN_CHANNELS];
  logic signed [PROD_W-1:0] prod_q [IN_CHANNELS];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] bias_q;

  // result shaping
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] shifted;
  logic [OUT_W-1:0]        relu_val;

  logic signed [DATA_W-1:0] bias_mem [OUT_CHANNELS];

  logic bad_idx, w_in_range, p_in_range, b_in_range, is_issue;

  assign busy = run_q;

  assign bad_idx    = 32'(idx_q) >= O_DEPTH;
  assign w_in_range = 32'(idx_q) < W_DEPTH;
  assign p_in_range = 32'(idx_q) < P_DEPTH;
  assign b_in_range = 32'(idx_q) < OUT_CHANNELS;
  assign is_issue   = cw.uop == UOP_ISSUE;

  // --------------------------------------------------------------------------
  // sequencer: next step
  // --------------------------------------------------------------------------
  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (!run_q) begin
      if (start) begin
        run_d  = 1'b1;
        step_d = entry_of(op_e'(operation_i));
      end
    end else begin
      case (cw.seq)
        SEQ_NEXT: step_d = step_q + 1'b1;
        SEQ_JUMP: step_d = cw.target;
        SEQ_LOOP: step_d = (tap_q != TAP_W'(TAPS - 1)) ? cw.target : step_q + 1'b1;
        SEQ_IF_BAD: step_d = bad_idx ? cw.target : step_q + 1'b1;
        SEQ_DONE: run_d = 1'b0;
        default: run_d = 1'b0;
      endcase
    end
  end

  // sequencer: control word out of the program store
  always_comb begin
    if (run_q) begin
      cw = ucode(step_q);
    end else begin
      cw = CW_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  // capture the transaction at acceptance
  always_ff @(posedge clk_i) begin
    if (start && !run_q) begin
      idx_q <= index_i;
      val_q <= value_i;
    end
  end

  // --------------------------------------------------------------------------
  // index decomposition: reciprocal multiply for the quotient, then a
  // constant multiply and subtract for the remainder
  // --------------------------------------------------------------------------
  assign div_src  = (cw.src == SRC_REM) ? rem_q : idx_q;
  assign div_prod = DIV_W'(div_src) * DIV_W'(div_recip(cw.div));
  assign den_prod = (2*IDX_W)'(quo_q) * (2*IDX_W)'(div_den(cw.div));

  // base addresses of the kernel window
  assign pa_base = (2*IDX_W)'(quo_q) * (2*IDX_W)'(IN_SIZE) + (2*IDX_W)'(rem_q);
  assign wa_base = (2*IDX_W)'(q1_q) * (2*IDX_W)'(TAPS);

  always_ff @(posedge clk_i) begin
    case (cw.uop)
      UOP_QUOT: begin
        q1_q  <= quo_q;
        quo_q <= div_prod[RECIP_SHIFT +: IDX_W];
      end
      UOP_REM: begin
        rem_q <= div_src - den_prod[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // tap walk over the kernel window
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (cw.uop)
      UOP_SETUP: begin
        pa_q   <= PA_W'(pa_base);
        wa_q   <= WA_W'(wa_base);
        kc_q   <= '0;
        tap_q  <= '0;
        bias_q <= bias_mem[q1_q[OC_W-1:0]];
      end
      UOP_ISSUE: begin
        wa_q  <= wa_q + 1'b1;
        tap_q <= tap_q + 1'b1;
        if (kc_q == KC_W'(KERNEL_SIZE - 1)) begin
          // next kernel row
          kc_q <= '0;
          pa_q <= pa_q + PA_W'(IN_SIZE - KERNEL_SIZE + 1);
        end else begin
          kc_q <= kc_q + 1'b1;
          pa_q <= pa_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // per-channel weight and pixel memories
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < IN_CHANNELS; g++) begin : g_chan
    logic signed [DATA_W-1:0] w_mem [OUT_CHANNELS * TAPS];
    logic signed [DATA_W-1:0] p_mem [PIX_PLANE];
    logic [2*IDX_W-1:0]       w_wr_addr;

    assign w_wr_addr = (2*IDX_W)'(q1_q) * (2*IDX_W)'(TAPS) + (2*IDX_W)'(rem_q);

    always_ff @(posedge clk_i) begin
      if (cw.uop == UOP_WR_WEIGHT && w_in_range && quo_q == IDX_W'(g)) begin
        w_mem[WA_W'(w_wr_addr)] <= val_q;
      end
      w_rd_q[g] <= w_mem[wa_q];
    end

    always_ff @(posedge clk_i) begin
      if (cw.uop == UOP_WR_PIXEL && p_in_range && quo_q == IDX_W'(g)) begin
        p_mem[rem_q[PA_W-1:0]] <= val_q;
      end
      p_rd_q[g] <= p_mem[pa_q];
    end

    always_ff @(posedge clk_i) begin
      prod_q[g] <= p_rd_q[g] * w_rd_q[g];
    end
  end

  // bias store
  always_ff @(posedge clk_i) begin
    if (cw.uop == UOP_WR_BIAS && b_in_range) begin
      bias_mem[idx_q[OC_W-1:0]] <= val_q;
    end
  end

  // --------------------------------------------------------------------------
  // channel sum and accumulation
  // --------------------------------------------------------------------------
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < IN_CHANNELS; g++) begin
      sum_d = sum_d + SUM_W'(prod_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
    end else begin
      rd_v_q   <= is_issue;
      prod_v_q <= rd_v_q;
      sum_v_q  <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (cw.uop == UOP_SETUP) begin
      acc_q <= '0;
    end else if (sum_v_q) begin
      acc_q <= acc_q + ACC_W'(sum_q);
    end
  end

  // --------------------------------------------------------------------------
  // bias, ReLU, floor to Q8.8 and saturation
  // --------------------------------------------------------------------------
  assign total   = TOT_W'(acc_q) + TOT_W'($signed({bias_q, {FRAC_BITS{1'b0}}}));
  assign shifted = total >>> FRAC_BITS;

  always_comb begin
    if (total <= 0) begin
      relu_val = '0;
    end else if (shifted > TOT_W'(SAT_MAX)) begin
      relu_val = OUT_W'(SAT_MAX);
    end else begin
      relu_val = shifted[OUT_W-1:0];
    end
  end

  // result registers, strobe lasts one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (cw.uop == UOP_RESULT) || (cw.uop == UOP_BAD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.uop == UOP_RESULT) begin
      out_value_o <= relu_val;
      out_index_o <= idx_q;
      bad_index_o <= 1'b0;
    end else if (cw.uop == UOP_BAD) begin
      out_value_o <= '0;
      out_index_o <= idx_q;
      bad_index_o <= 1'b1;
    end
  end

endmodule
